// ===== hw/rtl/pcanon_pkg.sv =====
// Shared types and constants for the path canonicalizer.
`default_nettype none

package pcanon_pkg;

    localparam logic [7:0] SEP_CHAR  = 8'd47;
    localparam logic [7:0] DOT_CHAR  = 8'd46;
    // Longest canonical path that can be produced, in characters.
    localparam int         OUT_LIMIT = 64;

    typedef struct packed {
        logic [7:0] ch;
        logic       is_final;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_char;
        logic       out_final;
        logic       overflow;
    } t_out_item;

    typedef enum logic [1:0] {
        KIND_EMPTY,
        KIND_DOT,
        KIND_DOTDOT,
        KIND_OTHER
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FCLOSE,
        S_FORM,
        S_SEND
    } t_state;

    typedef struct packed {
        logic scan;
        logic close;
        logic rd_emit;
        logic load_out;
        logic advance;
        logic flush;
    } t_cmd;

    typedef struct packed {
        logic out_last;
    } t_sts;

endpackage

`default_nettype wire

// ===== hw/rtl/pcanon_dp.sv =====
// Datapath: character store, component start stack and output register.
`default_nettype none

module pcanon_dp #(
    parameter int STORE_CHARS    = 64,
    parameter int MAX_COMPONENTS = 32
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  pcanon_pkg::t_cmd      i_cmd,
    input  pcanon_pkg::t_in_item  i_in,
    output pcanon_pkg::t_sts      o_sts,
    output pcanon_pkg::t_out_item o_out
);
    import pcanon_pkg::*;

    localparam int SW   = $clog2(STORE_CHARS);
    localparam int LW   = $clog2(STORE_CHARS + 1);
    localparam int IW   = $clog2(MAX_COMPONENTS);
    localparam int CW   = $clog2(MAX_COMPONENTS + 1);
    localparam int SUMW = $clog2(STORE_CHARS + MAX_COMPONENTS + OUT_LIMIT + 2);

    logic [7:0]    r_char_store [STORE_CHARS];
    logic [SW-1:0] r_starts     [MAX_COMPONENTS];

    logic [CW-1:0] r_stack, n_stack;
    logic [LW-1:0] r_len,   n_len;
    logic [LW-1:0] r_cur,   n_cur;
    t_kind         r_kind,  n_kind;
    logic          r_ovf,   n_ovf;
    logic [LW-1:0] r_pos,   n_pos;
    logic [CW-1:0] r_k,     n_k;

    logic [7:0]    r_char_rd;
    logic [SW-1:0] r_start_rd;
    t_out_item     r_out;
    logic          r_slash;

    logic          wr_char;
    logic          wr_start;
    logic          do_close;
    logic [LW-1:0] close_len;
    logic [SUMW-1:0] limit_sum;
    logic [SW-1:0] char_rd_addr;
    logic [IW-1:0] start_rd_addr;
    logic          slash_due;
    logic          char_last;

    always_comb begin
        n_stack   = r_stack;
        n_len     = r_len;
        n_cur     = r_cur;
        n_kind    = r_kind;
        n_ovf     = r_ovf;
        n_pos     = r_pos;
        n_k       = r_k;
        wr_char   = 1'b0;
        wr_start  = 1'b0;
        do_close  = i_cmd.close || (i_cmd.scan && (i_in.ch == SEP_CHAR));
        close_len = r_cur;
        limit_sum = SUMW'(r_len) + SUMW'(r_stack) + SUMW'(1);

        if (i_cmd.scan && (i_in.ch != SEP_CHAR)) begin
            // The kind follows every character, stored or dropped.
            priority if ((r_kind == KIND_EMPTY) && (i_in.ch == DOT_CHAR)) begin
                n_kind = KIND_DOT;
            end else if ((r_kind == KIND_DOT) && (i_in.ch == DOT_CHAR)) begin
                n_kind = KIND_DOTDOT;
            end else begin
                n_kind = KIND_OTHER;
            end
            if (r_len < LW'(STORE_CHARS)) begin
                wr_char = 1'b1;
                n_len   = r_len + 1'b1;
            end else begin
                n_ovf = 1'b1;
            end
        end

        if (do_close) begin
            unique case (r_kind)
                KIND_DOTDOT: begin
                    // The top start entry was read in an earlier cycle: a push
                    // is always followed by at least two dots before this.
                    if (r_stack != '0) begin
                        n_stack   = r_stack - 1'b1;
                        close_len = LW'(r_start_rd);
                    end
                end
                KIND_OTHER: begin
                    if (r_len == r_cur) begin
                        close_len = r_len;
                    end else if ((r_stack >= CW'(MAX_COMPONENTS)) ||
                                 (limit_sum > SUMW'(OUT_LIMIT))) begin
                        n_ovf = 1'b1;
                    end else begin
                        wr_start  = 1'b1;
                        n_stack   = r_stack + 1'b1;
                        close_len = r_len;
                    end
                end
                KIND_EMPTY, KIND_DOT: begin
                    close_len = r_cur;
                end
            endcase
            n_len  = close_len;
            n_cur  = close_len;
            n_kind = KIND_EMPTY;
        end

        if (i_cmd.advance) begin
            if (r_slash) begin
                n_k = r_k + 1'b1;
            end else begin
                n_pos = r_pos + 1'b1;
            end
        end

        if (i_cmd.flush) begin
            n_stack = '0;
            n_len   = '0;
            n_cur   = '0;
            n_kind  = KIND_EMPTY;
            n_ovf   = 1'b0;
            n_pos   = '0;
            n_k     = '0;
        end
    end

    // Reads use next-cycle addresses so the data lines up with the registers.
    always_comb begin
        char_rd_addr = n_pos[SW-1:0];
        if (i_cmd.rd_emit) begin
            start_rd_addr = (n_k < CW'(MAX_COMPONENTS)) ? n_k[IW-1:0] : '0;
        end else begin
            start_rd_addr = (n_stack == '0) ? '0 : IW'(n_stack - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_char) begin
            r_char_store[r_len[SW-1:0]] <= i_in.ch;
        end
        r_char_rd <= r_char_store[char_rd_addr];
    end

    // A start written in the same cycle as it is read is passed straight through.
    always_ff @(posedge i_clk) begin
        if (wr_start) begin
            r_starts[r_stack[IW-1:0]] <= r_cur[SW-1:0];
        end
        if (wr_start && (start_rd_addr == r_stack[IW-1:0])) begin
            r_start_rd <= r_cur[SW-1:0];
        end else begin
            r_start_rd <= r_starts[start_rd_addr];
        end
    end

    always_comb begin
        slash_due = (r_stack == '0) ||
                    ((r_k < r_stack) && (r_pos == LW'(r_start_rd)));
        char_last = (LW'(r_pos + 1'b1) == r_len);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stack <= '0;
            r_len   <= '0;
            r_cur   <= '0;
            r_kind  <= KIND_EMPTY;
            r_ovf   <= 1'b0;
            r_pos   <= '0;
            r_k     <= '0;
        end else begin
            r_stack <= n_stack;
            r_len   <= n_len;
            r_cur   <= n_cur;
            r_kind  <= n_kind;
            r_ovf   <= n_ovf;
            r_pos   <= n_pos;
            r_k     <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_slash         <= slash_due;
            r_out.out_char  <= slash_due ? SEP_CHAR : r_char_rd;
            r_out.out_final <= (r_stack == '0) || (!slash_due && char_last);
            r_out.overflow  <= r_ovf;
        end
    end

    assign o_out          = r_out;
    assign o_sts.out_last = r_out.out_final;

endmodule

`default_nettype wire

// ===== hw/rtl/pcanon_ctrl.sv =====
// Controller state machine: scanning, final close and result sequencing.
`default_nettype none

module pcanon_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  wire                 i_in_final,
    input  wire                 i_out_ready,
    input  pcanon_pkg::t_sts    i_sts,
    output pcanon_pkg::t_cmd    o_cmd,
    output logic                o_in_ready,
    output logic                o_out_valid
);
    import pcanon_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_in_final) begin
                    n_state = S_FCLOSE;
                end
            end
            S_FCLOSE: begin
                n_state = S_FORM;
            end
            S_FORM: begin
                n_state = S_SEND;
            end
            S_SEND: begin
                if (i_out_ready) begin
                    n_state = i_sts.out_last ? S_IDLE : S_FORM;
                end
            end
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.scan = i_in_valid;
            end
            S_FCLOSE: begin
                o_cmd.close   = 1'b1;
                o_cmd.rd_emit = 1'b1;
            end
            S_FORM: begin
                o_cmd.load_out = 1'b1;
                o_cmd.rd_emit  = 1'b1;
            end
            S_SEND: begin
                o_out_valid   = 1'b1;
                o_cmd.rd_emit = 1'b1;
                o_cmd.advance = i_out_ready && !i_sts.out_last;
                o_cmd.flush   = i_out_ready && i_sts.out_last;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/path_canonicalizer_top.sv =====
// A non-final item is taken while idle; the block stays ready for the next item.
// After the final item the controller steps through S_FCLOSE and S_FORM; the first
// result is valid in S_SEND. Each further result is read in S_FORM, then presented in
// S_SEND, where it waits for out_ready; S_FORM is set by the registered store read.
// Reset is synchronous, active low, and clears all control state; stores keep junk.
`default_nettype none

module path_canonicalizer_top #(
    parameter int STORE_CHARS    = 64,
    parameter int MAX_COMPONENTS = 32
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    input  pcanon_pkg::t_in_item  i_in,
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    output pcanon_pkg::t_out_item o_out
);
    import pcanon_pkg::*;

    t_cmd cmd;
    t_sts sts;

    pcanon_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_final  (i_in.is_final),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid)
    );

    pcanon_dp #(
        .STORE_CHARS    (STORE_CHARS),
        .MAX_COMPONENTS (MAX_COMPONENTS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_in    (i_in),
        .o_sts   (sts),
        .o_out   (o_out)
    );

`ifndef SYNTHESIS
    // No item is taken while a result is pending.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input accepted while a result is pending");

    // A final item leads to a valid first result once the controller has passed S_FCLOSE and S_FORM.
    a_flush_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in.is_final) |=> ##2 o_out_valid)
        else $error("no result after final item");

    // Once the last result is taken, the block is ready for a new path.
    a_back_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_out.out_final) |=> o_in_ready)
        else $error("block not idle after last result");

    // The overflow flag is the same on every result of one path.
    a_ovf_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_out.out_final) |=> ##1
        (o_out_valid && (o_out.overflow == $past(o_out.overflow, 2))))
        else $error("overflow flag changed within a path");
`endif

endmodule

`default_nettype wire
